// File: rtl/lfu_pkg.sv
// shared types, constants and codes for the lfu cache table
package lfu_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [31:0]      MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [31:0]      COUNT_MAX  = 32'hFFFF_FFFF;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] use_count;
        logic [63:0] last_touch;
    } t_entry;

    typedef struct packed {
        logic match;
        logic better;
    } t_cmp_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE
    } t_state;

endpackage

// File: rtl/lfu_store.sv
// entry memory: one registered read port and one write port
module lfu_store
    import lfu_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int IW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/lfu_cmp.sv
// shared compare unit: key match and victim ordering for one entry
module lfu_cmp
    import lfu_pkg::*;
(
    input  logic        i_valid,
    input  t_entry      i_entry,
    input  logic [31:0] i_key,
    input  logic        i_have_best,
    input  logic [31:0] i_best_count,
    input  logic [63:0] i_best_touch,
    output t_cmp_res    o_res
);

    always_comb begin
        o_res.match  = i_valid && (i_entry.key == i_key);
        // lower count wins, then older touch; a full tie keeps the earlier slot
        o_res.better = i_valid && (!i_have_best ||
                       (i_entry.use_count < i_best_count) ||
                       ((i_entry.use_count == i_best_count) &&
                        (i_entry.last_touch < i_best_touch)));
    end

endmodule

// File: rtl/lfu_cache_table_unit.sv
// top level of the lfu cache table: sequencer, scan trackers and bookkeeping
//
// A get or put transaction is taken at a rising edge with start high and busy
// low. The block then scans every entry slot through one memory read port and
// one shared compare unit, one slot a cycle, tracking the key match, the
// replacement victim and the first free slot. One drain cycle finishes the
// compare of the last slot, and a write cycle updates the chosen slot.
// The result shows on o_hit, o_read_value and o_evicted with o_strobe high for
// one cycle after the write cycle. busy drops during the write cycle, so the
// next item can be taken in the write cycle of the one before.
// The receiver cannot stall: each result is valid for its strobe cycle only.
// The capacity register is written through i_cfg_valid / o_cfg_ready /
// i_cfg_data; the user must write it only while no transaction is in flight,
// and the block itself does not enforce this. o_cfg_ready is always high.
// Reset empties the cache, clears the access clock and sets the capacity to
// 16; entry contents are not cleared, only the valid bits.
module lfu_cache_table_unit
    import lfu_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic signed [31:0] i_lookup_key,
    input  logic signed [31:0] i_write_value,
    output logic               o_strobe,
    output logic               o_hit,
    output logic signed [31:0] o_read_value,
    output logic               o_evicted,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_data
);

    localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] MAX_EXT  = CW'(MAX_ENTRIES);

    t_state r_state, n_state;

    logic [CAP_W-1:0]       r_capacity;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [OCC_W-1:0]       r_occ;
    logic [63:0]            r_clock;

    logic        r_cmd;
    logic [31:0] r_key;
    logic [31:0] r_val;

    logic [IW-1:0] r_idx;
    logic          r_cmp_on;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_valid;

    logic          r_have_match;
    logic [IW-1:0] r_match_idx;
    logic [31:0]   r_match_value;
    logic [31:0]   r_match_count;
    logic          r_have_best;
    logic [IW-1:0] r_best_idx;
    logic [31:0]   r_best_count;
    logic [63:0]   r_best_touch;
    logic          r_have_free;
    logic [IW-1:0] r_free_idx;

    logic        r_strobe;
    logic        r_hit;
    logic [31:0] r_read_value;
    logic        r_evicted;

    t_entry   rd_entry;
    t_cmp_res cmp_res;

    logic          accept;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic          set_valid;
    logic          occ_inc;
    logic [31:0]   res_value;
    logic          res_evicted;
    logic [CW-1:0] cap_ext;
    logic [CW-1:0] cap_eff;
    logic [CW-1:0] occ_ext;
    logic [31:0]   count_inc;

    lfu_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IW          (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_entry),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    lfu_cmp u_cmp (
        .i_valid      (r_cmp_valid),
        .i_entry      (rd_entry),
        .i_key        (r_key),
        .i_have_best  (r_have_best),
        .i_best_count (r_best_count),
        .i_best_touch (r_best_touch),
        .o_res        (cmp_res)
    );

    assign busy        = (r_state == S_SCAN) || (r_state == S_DRAIN);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign cap_ext   = CW'(r_capacity);
    assign cap_eff   = (cap_ext > MAX_EXT) ? MAX_EXT : cap_ext;
    assign occ_ext   = CW'(r_occ);
    assign count_inc = (r_match_count == COUNT_MAX) ? r_match_count : r_match_count + 32'd1;

    // next state and write-back decision
    always_comb begin
        n_state     = r_state;
        wr_en       = 1'b0;
        wr_addr     = r_match_idx;
        wr_data     = '{key: r_key, value: r_match_value, use_count: count_inc,
                        last_touch: r_clock};
        set_valid   = 1'b0;
        occ_inc     = 1'b0;
        res_value   = 32'd0;
        res_evicted = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = accept ? S_SCAN : S_IDLE;
                if (r_cmd == CMD_GET) begin
                    if (r_have_match) begin
                        res_value = r_match_value;
                        wr_en     = 1'b1;
                    end else begin
                        res_value = MISS_VALUE;
                    end
                end else if (cap_eff != '0) begin
                    if (r_have_match) begin
                        wr_en         = 1'b1;
                        wr_data.value = r_val;
                    end else begin
                        wr_data = '{key: r_key, value: r_val, use_count: 32'd1,
                                    last_touch: r_clock};
                        if ((occ_ext >= cap_eff) && r_have_best) begin
                            res_evicted = 1'b1;
                            wr_addr     = r_best_idx;
                            wr_en       = 1'b1;
                            set_valid   = 1'b1;
                        end else begin
                            occ_inc   = 1'b1;
                            wr_addr   = r_free_idx;
                            wr_en     = r_have_free;
                            set_valid = r_have_free;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAP_RESET;
            r_valid      <= '0;
            r_occ        <= '0;
            r_clock      <= '0;
            r_cmp_on     <= 1'b0;
            r_have_match <= 1'b0;
            r_have_best  <= 1'b0;
            r_have_free  <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end

            // compare stage runs in the cycle after its read address
            r_cmp_on    <= (r_state == S_SCAN);
            r_cmp_idx   <= r_idx;
            r_cmp_valid <= r_valid[r_idx];

            if (r_state == S_SCAN) begin
                r_idx <= r_idx + IW'(1);
            end

            if (r_cmp_on) begin
                if (cmp_res.match && !r_have_match) begin
                    r_have_match  <= 1'b1;
                    r_match_idx   <= r_cmp_idx;
                    r_match_value <= rd_entry.value;
                    r_match_count <= rd_entry.use_count;
                end
                if (cmp_res.better) begin
                    r_have_best  <= 1'b1;
                    r_best_idx   <= r_cmp_idx;
                    r_best_count <= rd_entry.use_count;
                    r_best_touch <= rd_entry.last_touch;
                end
                if (!r_cmp_valid && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= r_cmp_idx;
                end
            end

            r_strobe <= (r_state == S_WRITE);
            if (r_state == S_WRITE) begin
                r_hit        <= r_have_match;
                r_read_value <= res_value;
                r_evicted    <= res_evicted;
                r_clock      <= r_clock + 64'd1;
                if (set_valid) begin
                    r_valid[wr_addr] <= 1'b1;
                end
                if (occ_inc) begin
                    r_occ <= r_occ + OCC_W'(1);
                end
            end

            if (accept) begin
                r_cmd        <= i_command;
                r_key        <= i_lookup_key;
                r_val        <= i_write_value;
                r_idx        <= '0;
                r_have_match <= 1'b0;
                r_have_best  <= 1'b0;
                r_have_free  <= 1'b0;
            end
        end
    end

    assign o_strobe     = r_strobe;
    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;
    assign o_evicted    = r_evicted;

endmodule

// File: test/lfu_cache_table_unit_test.sv
// testbench for the lfu cache table: directed and random get/put traffic against a scan predictor
`timescale 1ns / 1ps

module lfu_cache_table_unit_test;
    import lfu_pkg::*;

    localparam int SLOTS          = DEF_MAX_ENTRIES;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int POOL_SIZE      = 24;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
    } t_access_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_command;
    logic signed [31:0] i_lookup_key;
    logic signed [31:0] i_write_value;
    logic               o_strobe;
    logic               o_hit;
    logic signed [31:0] o_read_value;
    logic               o_evicted;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CAP_W-1:0]   i_cfg_data;

    // predictor state
    bit               slot_valid [SLOTS];
    logic [31:0]      slot_key   [SLOTS];
    logic [31:0]      slot_value [SLOTS];
    logic [31:0]      slot_count [SLOTS];
    logic [63:0]      slot_touch [SLOTS];
    int unsigned      fill_level;
    logic [63:0]      access_tick;
    logic [CAP_W-1:0] capacity_setting;

    t_access_result pending_results[$];
    t_access_result due_result;
    logic [31:0]    key_pool [POOL_SIZE];
    bit             idle_on;
    int             error_count = 0;
    int             stall_cycles = 0;

    lfu_cache_table_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_strobe      (o_strobe),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void bump_use(int idx);
        if (slot_count[idx] != COUNT_MAX) slot_count[idx] = slot_count[idx] + 1;
        slot_touch[idx] = access_tick;
    endfunction

    function automatic t_access_result lfu_predict(logic cmd, logic [31:0] key,
                                                   logic [31:0] val);
        t_access_result res;
        int             slot;
        int             target;
        int unsigned    eff_cap;
        slot   = -1;
        target = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && slot_valid[i] && slot_key[i] == key) slot = i;
        end
        eff_cap        = (capacity_setting > SLOTS) ? SLOTS : capacity_setting;
        res.hit        = (slot >= 0);
        res.read_value = '0;
        res.evicted    = 1'b0;
        if (cmd == CMD_GET) begin
            if (slot >= 0) begin
                res.read_value = slot_value[slot];
                bump_use(slot);
            end else begin
                res.read_value = MISS_VALUE;
            end
        end else if (eff_cap != 0) begin
            if (slot >= 0) begin
                slot_value[slot] = val;
                bump_use(slot);
            end else begin
                if (fill_level >= eff_cap) begin
                    // lowest count first, then the oldest touch, then the lowest index
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_valid[i] && (target < 0 ||
                            slot_count[i] < slot_count[target] ||
                            (slot_count[i] == slot_count[target] &&
                             slot_touch[i] < slot_touch[target])))
                            target = i;
                    end
                end
                if (target >= 0) begin
                    res.evicted = 1'b1;
                end else begin
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (!slot_valid[i]) target = i;
                    end
                    fill_level++;
                end
                if (target >= 0) begin
                    slot_valid[target] = 1'b1;
                    slot_key[target]   = key;
                    slot_value[target] = val;
                    slot_count[target] = 32'd1;
                    slot_touch[target] = access_tick;
                end
            end
        end
        access_tick = access_tick + 1;
        return res;
    endfunction

    task automatic send_access(input logic cmd, input logic [31:0] key,
                               input logic [31:0] val);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            // sometimes let the block go idle first so the gap lands after busy drops
            if ($urandom_range(0, 1) == 1) begin
                while (busy) @(negedge i_clk);
            end
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        start         = 1'b1;
        i_command     = cmd;
        i_lookup_key  = key;
        i_write_value = val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(lfu_predict(cmd, key, val));
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        capacity_setting = cap;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_field_extremes();
        send_access(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_access(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_access(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_access(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_access(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_access(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_access(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        // stored -1 reads back like a miss, only hit tells them apart
        send_access(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_access(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
        send_access(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_capacity_lowered();
        // four entries held, capacity two: new keys evict and reuse the slot
        write_capacity(5'd2);
        send_access(CMD_PUT, 32'h0000_0055, 32'hA5A5_A5A5);
        send_access(CMD_PUT, 32'h0000_00AA, 32'h5A5A_5A5A);
        send_access(CMD_GET, 32'h0000_00AA, 32'h0000_0000);
        send_access(CMD_GET, 32'h0000_00AA, 32'h0000_0000);
        // equal counts: the least recently touched entry goes
        send_access(CMD_PUT, 32'h0000_0033, 32'h0F0F_0F0F);
        send_access(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    endtask

    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_access(CMD_PUT, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
        send_access(CMD_PUT, 32'h0000_0099, 32'hCAFE_F00D);
        send_access(CMD_GET, 32'h0000_0099, 32'h0000_0000);
        send_access(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_capacity_saturate();
        write_capacity(5'd31);
        send_access(CMD_PUT, 32'h0000_1111, 32'h1111_0000);
        send_access(CMD_PUT, 32'h0000_2222, 32'h2222_0000);
        send_access(CMD_GET, 32'h0000_1111, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] phase_caps [9] = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0,
                                             5'd9, 5'd17, 5'd2, 5'd16};
        int               eff_cap;
        int               pool_top;
        logic             cmd;
        logic [31:0]      key;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        for (int p = 0; p < 9; p++) begin
            write_capacity(phase_caps[p]);
            idle_on  = (p != 8);
            eff_cap  = (phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p];
            // a pool a little larger than the capacity gives both hits and evictions
            pool_top = (eff_cap == 0) ? 7 : ((eff_cap + 3 > POOL_SIZE - 1) ?
                                             POOL_SIZE - 1 : eff_cap + 3);
            repeat (50) begin
                cmd = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_top)];
                else key = $urandom;
                send_access(cmd, key, $urandom);
            end
        end
    endtask

    // result checker: the receiver cannot stall, so every strobe is a transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result hit %b read_value %h evicted %b",
                         $time, o_hit, o_read_value, o_evicted);
                error_count++;
            end else begin
                due_result = pending_results.pop_front();
                if (o_hit !== due_result.hit) begin
                    $display("%0t: hit expected %b actual %b",
                             $time, due_result.hit, o_hit);
                    error_count++;
                end
                if (o_read_value !== due_result.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, due_result.read_value, o_read_value);
                    error_count++;
                end
                if (o_evicted !== due_result.evicted) begin
                    $display("%0t: evicted expected %b actual %b",
                             $time, due_result.evicted, o_evicted);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_command     = CMD_GET;
        i_lookup_key  = '0;
        i_write_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = CAP_RESET;
        idle_on       = 1'b1;
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        fill_level       = 0;
        access_tick      = '0;
        capacity_setting = CAP_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_field_extremes();
        test_capacity_lowered();
        test_capacity_zero();
        test_capacity_saturate();
        test_random_traffic();

        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
